### sv/mbd_pkg.sv
// Shared types and constants for the 2x2 box-filter mip level generator.
// No dependencies; every other file of the block refers to this package.
package mbd_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_CHANNELS   = 4;
   localparam int ROW_LIMIT      = 4096;
   localparam int LANE_COUNT     = 4;
   localparam int CHAN_BITS      = 8;
   localparam int LANE_BITS      = CHAN_BITS + 1;
   localparam int SUM_BITS       = CHAN_BITS + 2;
   localparam int STORE_DEPTH    = MAX_WIDTH / 2;
   localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
   localparam int STORE_BITS     = LANE_COUNT * LANE_BITS;
   localparam int POS_BITS       = 12;
   localparam int DIM_BITS       = 13;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

   typedef struct packed {
      logic [CHAN_BITS-1:0] chan_in_3;
      logic [CHAN_BITS-1:0] chan_in_2;
      logic [CHAN_BITS-1:0] chan_in_1;
      logic [CHAN_BITS-1:0] chan_in_0;
   } req_payload_type;

   typedef struct packed {
      logic                 frame_last;
      logic [CHAN_BITS-1:0] chan_out_3;
      logic [CHAN_BITS-1:0] chan_out_2;
      logic [CHAN_BITS-1:0] chan_out_1;
      logic [CHAN_BITS-1:0] chan_out_0;
   } rsp_payload_type;

   // Controls from the top level to one channel lane.
   typedef struct packed {
      logic take;        // request accepted this cycle
      logic pend_load;   // pixel sits at an even column: keep it
      logic self_pair;   // one pixel wide image: pair the pixel with itself
      logic self_other;  // one pixel high image: pair the row with itself
      logic chan_on;     // channel is below the channel count
   } lane_ctl_type;

endpackage

### sv/mbd_line_store.sv
// Line store holding the horizontal pair sums of an even input row.
// Depends on mbd_pkg for depth and word width; read data is registered.
module mbd_line_store (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic                                rd_en,
   input  logic [mbd_pkg::ADDR_BITS-1:0]       addr,
   input  logic [mbd_pkg::STORE_BITS-1:0]      wr_data,
   output logic [mbd_pkg::STORE_BITS-1:0]      rd_data
);

   logic [mbd_pkg::STORE_BITS-1:0] mem_ff [mbd_pkg::STORE_DEPTH];
   logic [mbd_pkg::STORE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/mbd_lane.sv
// One channel lane: forms the horizontal pair sum and the final 2x2 average.
// Depends on mbd_pkg for widths and the lane control struct.
module mbd_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  mbd_pkg::lane_ctl_type              ctl,
   input  logic [mbd_pkg::CHAN_BITS-1:0]      pix,
   input  logic [mbd_pkg::LANE_BITS-1:0]      upper,
   output logic [mbd_pkg::LANE_BITS-1:0]      pair,
   output logic [mbd_pkg::CHAN_BITS-1:0]      result
);

   logic [mbd_pkg::CHAN_BITS-1:0] pend_ff;
   logic [mbd_pkg::CHAN_BITS-1:0] pend_in;
   logic [mbd_pkg::LANE_BITS-1:0] s1_pair_ff;
   logic [mbd_pkg::LANE_BITS-1:0] other;
   logic [mbd_pkg::SUM_BITS-1:0]  sum;

   always_comb begin
      if (ctl.self_pair) begin
         pair = {1'b0, pix} + {1'b0, pix};
      end else begin
         pair = {1'b0, pend_ff} + {1'b0, pix};
      end
      pend_in = (ctl.take && ctl.pend_load) ? pix : pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         s1_pair_ff <= pair;
      end
   end

   // The average is the sum of both pair sums divided by four, truncated.
   always_comb begin
      other  = ctl.self_other ? s1_pair_ff : upper;
      sum    = {1'b0, s1_pair_ff} + {1'b0, other};
      result = ctl.chan_on ? sum[mbd_pkg::SUM_BITS-1:2] : '0;
   end

endmodule

### sv/mip_box_downsample_2x2.sv
// Top level of the 2x2 box-filter mip level generator.
// Depends on mbd_pkg, mbd_lane and mbd_line_store.
//
// The block takes an image in raster order, one pixel of up to four 8-bit
// channels per request, and produces the next mip level: each output channel
// is the sum of a 2x2 block of input pixels shifted right by two. Four channel
// lanes work side by side on the channels of a pixel; the top level merges
// their bytes into one result register. One request is taken every clock
// cycle at a sustained rate while results are taken. A single port on the
// line store is enough for this, because a pixel on an even row only writes
// it and a pixel on an odd row only reads it. A request that completes its
// block is held in stage one after it is taken, and its result moves on to
// the result register as soon as that register is free or being emptied.
// The result register lets the next request in while a result still waits to
// be taken; only when both stage one and the result register are full does
// the input stall. Only the second pixel of each horizontal pair on an odd row
// gives a result; an odd last column or row is consumed silently. A one pixel
// wide or high image pairs each pixel or row with itself. Width and height of
// zero count as one, larger values saturate at 4096. Configuration must be
// written while the block is idle, and the image positions are not moved by a
// write.
module mip_box_downsample_2x2 (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mbd_pkg::req_payload_type               req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mbd_pkg::rsp_payload_type               rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mbd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [mbd_pkg::DIM_BITS-1:0]           csr_data
);

   localparam int LC = mbd_pkg::LANE_COUNT;
   localparam int LB = mbd_pkg::LANE_BITS;
   localparam int CB = mbd_pkg::CHAN_BITS;
   localparam int PB = mbd_pkg::POS_BITS;
   localparam int DB = mbd_pkg::DIM_BITS;

   // Configuration registers.
   logic [DB-1:0]                   width_ff, width_in;
   logic [DB-1:0]                   height_ff, height_in;
   logic [mbd_pkg::COUNT_BITS-1:0]  count_ff, count_in;

   // Image position.
   logic [PB-1:0] col_ff, col_in;
   logic [PB-1:0] row_ff, row_in;

   // Stage one: an accepted request that will give a result.
   logic s1_valid_ff, s1_valid_in;
   logic s1_self_ff;
   logic s1_last_ff;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   mbd_pkg::rsp_payload_type  rsp_payload_ff;

   logic          take, advance, out_free;
   logic [DB-1:0] w_eff, h_eff;
   logic          w_one, h_one;
   logic [PB-1:0] ow, oh, x, y;
   logic          have_pair, in_range, emit, store_wr, store_rd, last;

   logic [CB-1:0]                    pix    [LC];
   logic [LB-1:0]                    pair   [LC];
   logic [LB-1:0]                    upper  [LC];
   logic [CB-1:0]                    result [LC];
   mbd_pkg::lane_ctl_type            ctl    [LC];
   logic [mbd_pkg::STORE_BITS-1:0]   wr_data, rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      count_in  = count_ff;
      if (csr_valid) begin
         case (csr_index)
            mbd_pkg::REG_IMAGE_WIDTH:   width_in  = csr_data;
            mbd_pkg::REG_IMAGE_HEIGHT:  height_in = csr_data;
            mbd_pkg::REG_CHANNEL_COUNT: count_in  = csr_data[mbd_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DB'(mbd_pkg::MAX_WIDTH);
         height_ff <= DB'(mbd_pkg::ROW_LIMIT);
         count_ff  <= mbd_pkg::COUNT_BITS'(mbd_pkg::MAX_CHANNELS);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         count_ff  <= count_in;
      end
   end

   // Effective image size, output size and output coordinates.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DB'(1);
      end else if (width_ff > DB'(mbd_pkg::MAX_WIDTH)) begin
         w_eff = DB'(mbd_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = DB'(1);
      end else if (height_ff > DB'(mbd_pkg::ROW_LIMIT)) begin
         h_eff = DB'(mbd_pkg::ROW_LIMIT);
      end else begin
         h_eff = height_ff;
      end
      w_one = (w_eff == DB'(1));
      h_one = (h_eff == DB'(1));
      ow    = (w_eff[DB-1:1] == '0) ? PB'(1) : w_eff[DB-1:1];
      oh    = (h_eff[DB-1:1] == '0) ? PB'(1) : h_eff[DB-1:1];
      x     = w_one ? col_ff : {1'b0, col_ff[PB-1:1]};
      y     = h_one ? row_ff : {1'b0, row_ff[PB-1:1]};

      have_pair = w_one || col_ff[0];
      in_range  = (x < ow) && (y < oh);
      emit      = have_pair && in_range && (h_one || row_ff[0]);
      store_wr  = take && have_pair && in_range && !h_one && !row_ff[0];
      store_rd  = take && have_pair && in_range && !h_one && row_ff[0];
      last      = (x == ow - PB'(1)) && (y == oh - PB'(1));
   end

   // Handshake: the result register frees stage one, stage one frees the input.
   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      advance   = s1_valid_ff && out_free;
      req_ready = !s1_valid_ff || out_free;
      take      = req_valid && req_ready;

      s1_valid_in = s1_valid_ff;
      if (take && emit) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      col_in = col_ff;
      row_in = row_ff;
      if (take) begin
         if ({1'b0, col_ff} + DB'(1) >= w_eff) begin
            col_in = '0;
            row_in = ({1'b0, row_ff} + DB'(1) >= h_eff) ? '0 : row_ff + PB'(1);
         end else begin
            col_in = col_ff + PB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_self_ff <= h_one;
         s1_last_ff <= last;
      end
   end

   // Lanes: one per channel byte of the pixel.
   assign pix[0] = req_payload.chan_in_0;
   assign pix[1] = req_payload.chan_in_1;
   assign pix[2] = req_payload.chan_in_2;
   assign pix[3] = req_payload.chan_in_3;

   for (genvar c = 0; c < LC; c++) begin : g_lane
      always_comb begin
         ctl[c].take       = take;
         ctl[c].pend_load  = !w_one && !col_ff[0];
         ctl[c].self_pair  = w_one;
         ctl[c].self_other = s1_self_ff;
         ctl[c].chan_on    = (c < mbd_pkg::MAX_CHANNELS)
                             && (mbd_pkg::COUNT_BITS'(c) < count_ff);
      end

      assign wr_data[c*LB +: LB] = pair[c];
      assign upper[c]            = rd_data[c*LB +: LB];

      mbd_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl[c]),
         .pix    (pix[c]),
         .upper  (upper[c]),
         .pair   (pair[c]),
         .result (result[c])
      );
   end

   mbd_line_store u_line_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .rd_en   (store_rd),
      .addr    (x[mbd_pkg::ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Merging stage: collect the lane bytes into the result register.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff.chan_out_0 <= result[0];
         rsp_payload_ff.chan_out_1 <= result[1];
         rsp_payload_ff.chan_out_2 <= result[2];
         rsp_payload_ff.chan_out_3 <= result[3];
         rsp_payload_ff.frame_last <= s1_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### sv/mbd_checker.sv
// Port-level checks for the 2x2 box-filter mip level generator, bound to it.
// Depends on mbd_pkg; sees only the ports of mip_box_downsample_2x2.
module mbd_port_checks (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input mbd_pkg::rsp_payload_type            rsp_payload,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [mbd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input logic [mbd_pkg::DIM_BITS-1:0]        csr_data
);

   logic [mbd_pkg::COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (csr_valid && csr_ready && (csr_index == mbd_pkg::REG_CHANNEL_COUNT)) begin
         count_in = csr_data[mbd_pkg::COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= mbd_pkg::COUNT_BITS'(mbd_pkg::MAX_CHANNELS);
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With no result waiting, the block must take an offered request.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // Channels at or above the channel count read as zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((count_ff > 3'd0) || (rsp_payload.chan_out_0 == '0))
         && ((count_ff > 3'd1) || (rsp_payload.chan_out_1 == '0))
         && ((count_ff > 3'd2) || (rsp_payload.chan_out_2 == '0))
         && ((count_ff > 3'd3) || (rsp_payload.chan_out_3 == '0)))
      else $error("unused channel not zero");

endmodule

bind mip_box_downsample_2x2 mbd_port_checks u_mbd_port_checks (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_index   (csr_index),
   .csr_data    (csr_data)
);
